@@ design/five_bar_leg_inverse_kinematics_macros.svh @@
// Assertion helpers for the checker file.
`ifndef FIVE_BAR_LEG_INVERSE_KINEMATICS_MACROS_SVH
`define FIVE_BAR_LEG_INVERSE_KINEMATICS_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FBIK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbik check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define FBIK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbik check failed");

`endif

@@ design/fbik_pkg.sv @@
package fbik_pkg;

    // Field widths
    localparam int POS_W     = 24;
    localparam int LEN_W     = 23;
    localparam int DX_W      = POS_W + 1;
    localparam int ANG_W     = 16;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 2;

    // CORDIC datapath
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    localparam int CW            = 48;
    localparam int ZW            = 34;

    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK            = 2'd0;
    localparam logic [STAT_W-1:0] STAT_Y_NONNEG      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LEFT_UNREACH  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RIGHT_UNREACH = 2'd3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_SPACING = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_ARM    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_ARM    = 2'd2;

    // Per-item context carried down a side pipeline
    typedef struct packed {
        logic                    tag;
        logic                    reach;
        logic                    neg;
        logic signed [15:0]      c;
        logic signed [DX_W-1:0]  dx;
        logic signed [POS_W-1:0] dy;
    } side_ctx_t;

    // Flags a side hands back to the top level
    typedef struct packed {
        logic tag;
        logic reach;
    } side_res_t;

    // atan(2^-i) in Q2.30, truncated
    function automatic logic signed [ZW-1:0] atan_q30(input int unsigned i);
        case (i)
            0:       return 34'sd843314856;
            1:       return 34'sd497837829;
            2:       return 34'sd263043836;
            3:       return 34'sd133525158;
            4:       return 34'sd67021686;
            5:       return 34'sd33543515;
            6:       return 34'sd16775850;
            7:       return 34'sd8388437;
            8:       return 34'sd4194282;
            9:       return 34'sd2097149;
            10:      return 34'sd1048575;
            11:      return 34'sd524287;
            12:      return 34'sd262143;
            13:      return 34'sd131071;
            14:      return 34'sd65535;
            15:      return 34'sd32767;
            16:      return 34'sd16383;
            17:      return 34'sd8191;
            18:      return 34'sd4095;
            19:      return 34'sd2047;
            20:      return 34'sd1023;
            21:      return 34'sd511;
            22:      return 34'sd255;
            23:      return 34'sd127;
            default: return '0;
        endcase
    endfunction

endpackage

@@ design/fbik_cordic.sv @@
module fbik_cordic (
    input  logic                            clk,
    input  logic                            en,
    input  logic signed [fbik_pkg::CW-1:0]  x_in,
    input  logic signed [fbik_pkg::CW-1:0]  y_in,
    output logic signed [fbik_pkg::ZW-1:0]  z_out
);
    import fbik_pkg::*;

    logic signed [CW-1:0] x_reg [0:CORDIC_N];
    logic signed [CW-1:0] y_reg [0:CORDIC_N];
    logic signed [ZW-1:0] z_reg [0:CORDIC_N];

    // Pre-rotate into the right half plane
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (x_in[CW-1])
            begin
                if (!y_in[CW-1])
                begin
                    x_reg[0] <= y_in;
                    y_reg[0] <= -x_in;
                    z_reg[0] <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg[0] <= -y_in;
                    y_reg[0] <= x_in;
                    z_reg[0] <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg[0] <= x_in;
                y_reg[0] <= y_in;
                z_reg[0] <= '0;
            end
        end
    end

    // One vectoring micro-rotation per stage
    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_iter
        logic y_pos;
        assign y_pos = !y_reg[i][CW-1] && (y_reg[i] != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_pos)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q30(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q30(i);
                end
            end
        end
    end

    assign z_out = z_reg[CORDIC_N];

endmodule

@@ design/fbik_side.sv @@
module fbik_side (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic [fbik_pkg::LEN_W-1:0]        upper_arm_length,
    input  logic [fbik_pkg::LEN_W-1:0]        lower_arm_length,
    input  logic signed [fbik_pkg::DX_W-1:0]  dx,
    input  logic signed [fbik_pkg::POS_W-1:0] dy,
    input  logic                              tag_in,
    output logic signed [fbik_pkg::ZW-1:0]    alpha,
    output logic signed [fbik_pkg::ZW-1:0]    beta,
    output fbik_pkg::side_res_t               res
);
    import fbik_pkg::*;

    localparam int DX2_W   = 2 * DX_W - 2;
    localparam int DY2_W   = 2 * POS_W - 1;
    localparam int S_W     = DX2_W + 1;
    localparam int SQ_W    = 2 * LEN_W;
    localparam int HI_W    = 2 * LEN_W + 2;
    localparam int T_W     = SQ_W + 1;
    localparam int SUM_W   = S_W + 2;
    localparam int NUM_W   = SUM_W + 7;
    localparam int AN_W    = NUM_W - 1;
    localparam int R1_W    = 64;
    localparam int ROOT1_W = R1_W / 2;
    localparam int REM1_W  = ROOT1_W + 3;
    localparam int PROD_W  = LEN_W + ROOT1_W;
    localparam int DEN_W   = PROD_W + 1;
    localparam int DIV_N   = 14;
    localparam int MAG_W   = DIV_N + 1;
    localparam int CSQ_W   = 2 * DIV_N + 1;
    localparam int R2_W    = 32;
    localparam int ROOT2_W = R2_W / 2;
    localparam int REM2_W  = ROOT2_W + 3;

    // ---------------- stage 1: squares ----------------
    logic signed [2*DX_W-1:0]  dx_sq;
    logic signed [2*POS_W-1:0] dy_sq;
    logic [LEN_W:0]            len_sum;
    logic [LEN_W-1:0]          len_diff;
    logic [HI_W-1:0]           hi_sq;
    logic [SQ_W-1:0]           lo_sq;
    logic [SQ_W-1:0]           l1_sq;
    logic [SQ_W-1:0]           l2_sq;

    assign dx_sq    = dx * dx;
    assign dy_sq    = dy * dy;
    assign len_sum  = {1'b0, upper_arm_length} + {1'b0, lower_arm_length};
    assign len_diff = (upper_arm_length >= lower_arm_length)
                    ? (upper_arm_length - lower_arm_length)
                    : (lower_arm_length - upper_arm_length);
    assign hi_sq    = len_sum * len_sum;
    assign lo_sq    = len_diff * len_diff;
    assign l1_sq    = upper_arm_length * upper_arm_length;
    assign l2_sq    = lower_arm_length * lower_arm_length;

    logic [DX2_W-1:0] p1_dx2_reg;
    logic [DY2_W-1:0] p1_dy2_reg;
    logic [HI_W-1:0]  p1_hi_reg;
    logic [SQ_W-1:0]  p1_lo_reg;
    logic [SQ_W-1:0]  p1_l1sq_reg;
    logic [SQ_W-1:0]  p1_l2sq_reg;
    logic             p1_l1nz_reg;
    side_ctx_t        p1_ctx_reg;
    side_ctx_t        p1_ctx_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_dx2_reg  <= dx_sq[DX2_W-1:0];
            p1_dy2_reg  <= dy_sq[DY2_W-1:0];
            p1_hi_reg   <= hi_sq;
            p1_lo_reg   <= lo_sq;
            p1_l1sq_reg <= l1_sq;
            p1_l2sq_reg <= l2_sq;
            p1_l1nz_reg <= (upper_arm_length != '0);
        end
    end

    always_comb
    begin
        p1_ctx_next     = '0;
        p1_ctx_next.tag = tag_in;
        p1_ctx_next.dx  = dx;
        p1_ctx_next.dy  = dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_ctx_reg <= '0;
        end
        else if (en)
        begin
            p1_ctx_reg <= p1_ctx_next;
        end
    end

    // ---------------- stage 2: squared distance ----------------
    logic [S_W-1:0]         p2_s_reg;
    logic signed [T_W-1:0]  p2_t_reg;
    logic [HI_W-1:0]        p2_hi_reg;
    logic [SQ_W-1:0]        p2_lo_reg;
    logic                   p2_l1nz_reg;
    side_ctx_t              p2_ctx_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_s_reg    <= {1'b0, p1_dx2_reg} + {2'b0, p1_dy2_reg};
            p2_t_reg    <= $signed({1'b0, p1_l1sq_reg}) - $signed({1'b0, p1_l2sq_reg});
            p2_hi_reg   <= p1_hi_reg;
            p2_lo_reg   <= p1_lo_reg;
            p2_l1nz_reg <= p1_l1nz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p2_ctx_reg <= '0;
        end
        else if (en)
        begin
            p2_ctx_reg <= p1_ctx_reg;
        end
    end

    // ---------------- stage 3: reach test, numerator ----------------
    logic             reach_next;
    logic [SUM_W-1:0] sum_next;
    side_ctx_t        p3_ctx_next;

    assign reach_next = p2_l1nz_reg && (p2_s_reg != '0)
                     && (p2_s_reg <= {1'b0, p2_hi_reg})
                     && (p2_s_reg >= {3'b0, p2_lo_reg});
    assign sum_next   = {{(SUM_W-T_W){p2_t_reg[T_W-1]}}, p2_t_reg} + {2'b0, p2_s_reg};

    always_comb
    begin
        p3_ctx_next       = p2_ctx_reg;
        p3_ctx_next.reach = reach_next;
    end

    // First root: D = floor(sqrt(S * 2^14)), one result bit per stage
    logic [R1_W-1:0]         q1_rad_reg  [0:ROOT1_W];
    logic [REM1_W-1:0]       q1_rem_reg  [0:ROOT1_W];
    logic [ROOT1_W-1:0]      q1_root_reg [0:ROOT1_W];
    logic signed [NUM_W-1:0] q1_num_reg  [0:ROOT1_W];
    side_ctx_t               q1_ctx_reg  [0:ROOT1_W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q1_rad_reg[0]  <= {1'b0, p2_s_reg, 14'b0};
            q1_rem_reg[0]  <= '0;
            q1_root_reg[0] <= '0;
            q1_num_reg[0]  <= $signed({sum_next, 7'b0});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            q1_ctx_reg[0] <= p3_ctx_next;
        end
    end

    for (genvar k = 0; k < ROOT1_W; k++)
    begin : g_root1
        logic [REM1_W-1:0] rem_sh;
        logic [REM1_W-1:0] trial;
        logic              fit;

        assign rem_sh = {q1_rem_reg[k][REM1_W-3:0], q1_rad_reg[k][R1_W-1:R1_W-2]};
        assign trial  = {1'b0, q1_root_reg[k], 2'b01};
        assign fit    = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q1_rad_reg[k+1]  <= {q1_rad_reg[k][R1_W-3:0], 2'b00};
                q1_rem_reg[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
                q1_root_reg[k+1] <= {q1_root_reg[k][ROOT1_W-2:0], fit};
                q1_num_reg[k+1]  <= q1_num_reg[k];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q1_ctx_reg[k+1] <= '0;
            end
            else if (en)
            begin
                q1_ctx_reg[k+1] <= q1_ctx_reg[k];
            end
        end
    end

    // ---------------- stage 4: denominator, magnitude of numerator ----------------
    logic [PROD_W-1:0] prod;
    logic [NUM_W-1:0]  num_abs;
    side_ctx_t         p4_ctx_next;

    assign prod    = upper_arm_length * q1_root_reg[ROOT1_W];
    assign num_abs = q1_num_reg[ROOT1_W][NUM_W-1] ? (-q1_num_reg[ROOT1_W])
                                                  : q1_num_reg[ROOT1_W];

    always_comb
    begin
        p4_ctx_next     = q1_ctx_reg[ROOT1_W];
        p4_ctx_next.neg = q1_num_reg[ROOT1_W][NUM_W-1];
    end

    // Restoring divide: cosine magnitude, one quotient bit per stage
    logic [DEN_W-1:0] dv_den_reg [0:DIV_N];
    logic [AN_W-1:0]  dv_rem_reg [0:DIV_N];
    logic [DIV_N-1:0] dv_q_reg   [0:DIV_N];
    logic             dv_ge_reg  [1:DIV_N];
    side_ctx_t        dv_ctx_reg [0:DIV_N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_den_reg[0] <= {prod, 1'b0};
            dv_rem_reg[0] <= num_abs[AN_W-1:0];
            dv_q_reg[0]   <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            dv_ctx_reg[0] <= p4_ctx_next;
        end
    end

    for (genvar j = 0; j < DIV_N; j++)
    begin : g_div
        logic [AN_W:0] rem2;
        logic [AN_W:0] den_ext;
        logic [AN_W:0] diff;
        logic          fit;

        assign rem2    = {dv_rem_reg[j], 1'b0};
        assign den_ext = {2'b0, dv_den_reg[j]};
        assign diff    = rem2 - den_ext;
        assign fit     = (rem2 >= den_ext);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_den_reg[j+1] <= dv_den_reg[j];
                dv_rem_reg[j+1] <= fit ? diff[AN_W-1:0] : rem2[AN_W-1:0];
                dv_q_reg[j+1]   <= {dv_q_reg[j][DIV_N-2:0], fit};
            end
        end

        // Clamp flag: numerator at or above the denominator
        if (j == 0)
        begin : g_ge_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_ge_reg[1] <= ({1'b0, dv_rem_reg[0]} >= den_ext);
                end
            end
        end
        else
        begin : g_ge_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_ge_reg[j+1] <= dv_ge_reg[j];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_ctx_reg[j+1] <= '0;
            end
            else if (en)
            begin
                dv_ctx_reg[j+1] <= dv_ctx_reg[j];
            end
        end
    end

    // ---------------- stage 5: signed cosine and its square ----------------
    logic [MAG_W-1:0]     mag;
    logic [2*MAG_W-1:0]   mag_sq;
    logic [MAG_W:0]       mag_ext;
    side_ctx_t            p5_ctx_next;
    logic [CSQ_W-1:0]     p5_csq_reg;
    side_ctx_t            p5_ctx_reg;

    assign mag     = dv_ge_reg[DIV_N] ? MAG_W'(16384) : {1'b0, dv_q_reg[DIV_N]};
    assign mag_sq  = mag * mag;
    assign mag_ext = {1'b0, mag};

    always_comb
    begin
        p5_ctx_next   = dv_ctx_reg[DIV_N];
        p5_ctx_next.c = dv_ctx_reg[DIV_N].neg ? $signed(-mag_ext) : $signed(mag_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p5_csq_reg <= mag_sq[CSQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p5_ctx_reg <= '0;
        end
        else if (en)
        begin
            p5_ctx_reg <= p5_ctx_next;
        end
    end

    // ---------------- stage 6 on: sine by second root ----------------
    logic [CSQ_W-1:0]   sin_sq;
    logic [R2_W-1:0]    q2_rad_reg  [0:ROOT2_W];
    logic [REM2_W-1:0]  q2_rem_reg  [0:ROOT2_W];
    logic [ROOT2_W-1:0] q2_root_reg [0:ROOT2_W];
    side_ctx_t          q2_ctx_reg  [0:ROOT2_W];

    assign sin_sq = CSQ_W'(1 << 28) - p5_csq_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q2_rad_reg[0]  <= {{(R2_W-CSQ_W){1'b0}}, sin_sq};
            q2_rem_reg[0]  <= '0;
            q2_root_reg[0] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q2_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            q2_ctx_reg[0] <= p5_ctx_reg;
        end
    end

    for (genvar k = 0; k < ROOT2_W; k++)
    begin : g_root2
        logic [REM2_W-1:0] rem_sh;
        logic [REM2_W-1:0] trial;
        logic              fit;

        assign rem_sh = {q2_rem_reg[k][REM2_W-3:0], q2_rad_reg[k][R2_W-1:R2_W-2]};
        assign trial  = {1'b0, q2_root_reg[k], 2'b01};
        assign fit    = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q2_rad_reg[k+1]  <= {q2_rad_reg[k][R2_W-3:0], 2'b00};
                q2_rem_reg[k+1]  <= fit ? (rem_sh - trial) : rem_sh;
                q2_root_reg[k+1] <= {q2_root_reg[k][ROOT2_W-2:0], fit};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                q2_ctx_reg[k+1] <= '0;
            end
            else if (en)
            begin
                q2_ctx_reg[k+1] <= q2_ctx_reg[k];
            end
        end
    end

    // ---------------- angle units ----------------
    side_ctx_t          ctx_end;
    logic signed [CW-1:0] beta_x;
    logic signed [CW-1:0] beta_y;
    logic signed [CW-1:0] alpha_x;
    logic signed [CW-1:0] alpha_y;

    assign ctx_end = q2_ctx_reg[ROOT2_W];
    assign beta_x  = $signed({{2{ctx_end.c[15]}}, ctx_end.c, 30'b0});
    assign beta_y  = $signed({2'b0, q2_root_reg[ROOT2_W], 30'b0});
    assign alpha_x = $signed({{(CW-DX_W-20){ctx_end.dx[DX_W-1]}}, ctx_end.dx, 20'b0});
    assign alpha_y = $signed({{(CW-POS_W-20){ctx_end.dy[POS_W-1]}}, ctx_end.dy, 20'b0});

    fbik_cordic u_beta (
        .clk   (clk),
        .en    (en),
        .x_in  (beta_x),
        .y_in  (beta_y),
        .z_out (beta)
    );

    fbik_cordic u_alpha (
        .clk   (clk),
        .en    (en),
        .x_in  (alpha_x),
        .y_in  (alpha_y),
        .z_out (alpha)
    );

    // Hold flags level with the angle units
    side_ctx_t cd_ctx_reg [0:CORDIC_N];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cd_ctx_reg[0] <= '0;
        end
        else if (en)
        begin
            cd_ctx_reg[0] <= ctx_end;
        end
    end

    for (genvar i = 0; i < CORDIC_N; i++)
    begin : g_ctx_delay
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cd_ctx_reg[i+1] <= '0;
            end
            else if (en)
            begin
                cd_ctx_reg[i+1] <= cd_ctx_reg[i];
            end
        end
    end

    assign res.tag   = cd_ctx_reg[CORDIC_N].tag;
    assign res.reach = cd_ctx_reg[CORDIC_N].reach;

endmodule

@@ design/five_bar_leg_inverse_kinematics.sv @@
// Channel   Direction  Handshake            Payload
// in        input      in_valid/in_ready    target_x, target_y
// out       output     out_valid/out_ready  left_angle, right_angle, status
// cfg       input      cfg_we (no wait)     cfg_index, cfg_data
//
// One target per cycle while no untaken result holds the output; each result passes through
// the two roots (one result bit per stage), the 14-bit divide and the CORDIC chain.
// Reset clears valid bits and loads the register defaults.
// A stall on the output freezes the whole pipeline; in_ready follows out_ready then.
module five_bar_leg_inverse_kinematics (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [fbik_pkg::POS_W-1:0]     target_x,
    input  logic signed [fbik_pkg::POS_W-1:0]     target_y,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fbik_pkg::ANG_W-1:0]     left_angle,
    output logic signed [fbik_pkg::ANG_W-1:0]     right_angle,
    output logic [fbik_pkg::STAT_W-1:0]           status,
    input  logic                                  cfg_we,
    input  logic [fbik_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fbik_pkg::LEN_W-1:0]            cfg_data
);
    import fbik_pkg::*;

    localparam int TH_W = ZW + 2;
    localparam int RS_W = TH_W - 18;

    // Configuration registers
    logic [LEN_W-1:0] half_spacing_reg;
    logic [LEN_W-1:0] upper_arm_reg;
    logic [LEN_W-1:0] lower_arm_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_spacing_reg <= LEN_W'(0);
            upper_arm_reg    <= LEN_W'(256);
            lower_arm_reg    <= LEN_W'(512);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HALF_SPACING: half_spacing_reg <= cfg_data;
                REG_UPPER_ARM:    upper_arm_reg    <= cfg_data;
                REG_LOWER_ARM:    lower_arm_reg    <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Advance everything unless the output holds an untaken result
    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Input stage: side offsets
    logic                    a_valid_reg;
    logic                    a_ynn_reg;
    logic signed [DX_W-1:0]  a_dxl_reg;
    logic signed [DX_W-1:0]  a_dxr_reg;
    logic signed [POS_W-1:0] a_dy_reg;
    logic signed [DX_W-1:0]  x_ext;
    logic signed [DX_W-1:0]  d_ext;

    assign x_ext = {target_x[POS_W-1], target_x};
    assign d_ext = $signed({2'b0, half_spacing_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ynn_reg <= !target_y[POS_W-1];
            a_dxl_reg <= x_ext + d_ext;
            a_dxr_reg <= x_ext - d_ext;
            a_dy_reg  <= target_y;
        end
    end

    // Both sides; the left carries the y flag, the right carries valid
    logic signed [ZW-1:0] alpha_l;
    logic signed [ZW-1:0] beta_l;
    logic signed [ZW-1:0] alpha_r;
    logic signed [ZW-1:0] beta_r;
    side_res_t            res_l;
    side_res_t            res_r;

    fbik_side u_left (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .upper_arm_length (upper_arm_reg),
        .lower_arm_length (lower_arm_reg),
        .dx               (a_dxl_reg),
        .dy               (a_dy_reg),
        .tag_in           (a_ynn_reg),
        .alpha            (alpha_l),
        .beta             (beta_l),
        .res              (res_l)
    );

    fbik_side u_right (
        .clk              (clk),
        .rst_n            (rst_n),
        .en               (en),
        .upper_arm_length (upper_arm_reg),
        .lower_arm_length (lower_arm_reg),
        .dx               (a_dxr_reg),
        .dy               (a_dy_reg),
        .tag_in           (a_valid_reg),
        .alpha            (alpha_r),
        .beta             (beta_r),
        .res              (res_r)
    );

    // Combine stage: drive angles with rounding bias, status
    logic                    e_valid_reg;
    logic [STAT_W-1:0]       e_status_reg;
    logic signed [TH_W-1:0]  e_th1_reg;
    logic signed [TH_W-1:0]  e_th2_reg;
    logic [STAT_W-1:0]       status_next;

    always_comb
    begin
        if (res_l.tag)
        begin
            status_next = STAT_Y_NONNEG;
        end
        else if (!res_l.reach)
        begin
            status_next = STAT_LEFT_UNREACH;
        end
        else if (!res_r.reach)
        begin
            status_next = STAT_RIGHT_UNREACH;
        end
        else
        begin
            status_next = STAT_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= res_r.tag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_status_reg <= status_next;
            e_th1_reg    <= TH_W'(alpha_l) - TH_W'(beta_l) + TH_W'(1 << 17);
            e_th2_reg    <= TH_W'(alpha_r) + TH_W'(beta_r) + TH_W'(1 << 17);
        end
    end

    // Scale to Q3.12 and saturate
    function automatic logic [ANG_W-1:0] to_q12(input logic signed [TH_W-1:0] th);
        logic [RS_W-1:0] r;
        r = th[TH_W-1:18];
        if (!r[RS_W-1] && (r[RS_W-2:ANG_W-1] != '0))
        begin
            return {1'b0, {(ANG_W-1){1'b1}}};
        end
        else if (r[RS_W-1] && (r[RS_W-2:ANG_W-1] != '1))
        begin
            return {1'b1, {(ANG_W-1){1'b0}}};
        end
        else
        begin
            return r[ANG_W-1:0];
        end
    endfunction

    // Output register
    logic [ANG_W-1:0]  left_angle_reg;
    logic [ANG_W-1:0]  right_angle_reg;
    logic [STAT_W-1:0] status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            status_reg <= e_status_reg;
            if (e_status_reg == STAT_OK)
            begin
                left_angle_reg  <= to_q12(e_th1_reg);
                right_angle_reg <= to_q12(e_th2_reg);
            end
            else
            begin
                left_angle_reg  <= '0;
                right_angle_reg <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign left_angle  = $signed(left_angle_reg);
    assign right_angle = $signed(right_angle_reg);
    assign status      = status_reg;

endmodule

@@ design/fbik_checker.sv @@
`include "five_bar_leg_inverse_kinematics_macros.svh"

module fbik_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              in_valid,
    input logic                              in_ready,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic [fbik_pkg::ANG_W-1:0]        left_angle,
    input logic [fbik_pkg::ANG_W-1:0]        right_angle,
    input logic [fbik_pkg::STAT_W-1:0]       status
);
    import fbik_pkg::*;

    // Any error result carries zero angles
    `FBIK_ASSERT_NOW(a_err_zero, out_valid && (status != STAT_OK), (left_angle == '0) && (right_angle == '0))

    // Input only backs up behind an untaken result
    `FBIK_ASSERT_NOW(a_ready_link, !in_ready, out_valid && !out_ready)

    // Untaken result holds
    `FBIK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(left_angle) && $stable(right_angle) && $stable(status))

    // Taking a result frees the input side in the same cycle
    `FBIK_ASSERT_NOW(a_take_frees, out_ready, in_ready)

    // Offered input waits for its transfer
    `FBIK_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid)

endmodule

bind five_bar_leg_inverse_kinematics fbik_checker u_fbik_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_angle  (left_angle),
    .right_angle (right_angle),
    .status      (status)
);

@@ tb/five_bar_leg_inverse_kinematics_test.sv @@
module five_bar_leg_inverse_kinematics_test;

    import fbik_pkg::*;

    localparam int  SETTLE_CYCLES = 120;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  CYCLE_LIMIT   = 300000;
    localparam longint ANGLE_TAB [24] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287,
        262143, 131071, 65535, 32767, 16383, 8191,
        4095, 2047, 1023, 511, 255, 127
    };
    localparam longint QUARTER_TURN = 1686629713;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
    } target_t;

    typedef struct {
        logic signed [ANG_W-1:0] left;
        logic signed [ANG_W-1:0] right;
        logic [STAT_W-1:0]       stat;
    } angles_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic signed [POS_W-1:0] target_x;
    logic signed [POS_W-1:0] target_y;
    logic out_valid;
    logic out_ready;
    logic signed [ANG_W-1:0] left_angle;
    logic signed [ANG_W-1:0] right_angle;
    logic [STAT_W-1:0] status;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LEN_W-1:0] cfg_data;

    // leg geometry as the predictor sees it
    longint spacing_q8;
    longint upper_q8;
    longint lower_q8;

    target_t pending_targets[$];
    angles_t expected_angles[$];
    int      errors;
    int      items_taken;
    int      results_seen;
    int      hold_orders;
    bit      gaps_on;
    int      cycles;

    five_bar_leg_inverse_kinematics dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .target_x   (target_x),
        .target_y   (target_y),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .left_angle (left_angle),
        .right_angle(right_angle),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint unsigned int_root(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // vectoring rotation, returns the angle of (vx, vy) in Q2.30
    function automatic longint vector_angle(longint vy, longint vx);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx = vy;
                vy = -t;
                z = QUARTER_TURN;
            end
            else
            begin
                vx = -vy;
                vy = t;
                z = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < CORDIC_N; i++)
        begin
            xs = vx >>> i;
            ys = vy >>> i;
            if (vy > 0)
            begin
                vx = vx + ys;
                vy = vy - xs;
                z += ANGLE_TAB[i];
            end
            else
            begin
                vx = vx - ys;
                vy = vy + xs;
                z -= ANGLE_TAB[i];
            end
        end
        return z;
    endfunction

    // direction and elbow angle of one side; returns 0 when out of reach
    function automatic bit solve_side(input longint dx, input longint dy,
                                      output longint dir, output longint elbow);
        longint unsigned dist2;
        longint unsigned root_len;
        longint unsigned rem;
        longint unsigned quo;
        longint num;
        longint den;
        longint mag;
        longint cosv;
        dir = 0;
        elbow = 0;
        dist2 = dx * dx + dy * dy;
        if (upper_q8 == 0 || dist2 == 0
            || dist2 > (upper_q8 + lower_q8) * (upper_q8 + lower_q8)
            || dist2 < (upper_q8 - lower_q8) * (upper_q8 - lower_q8))
            return 0;
        root_len = int_root(dist2 << 14);
        num = (upper_q8 * upper_q8 + longint'(dist2) - lower_q8 * lower_q8) * 128;
        den = 2 * upper_q8 * longint'(root_len);
        mag = num < 0 ? -num : num;
        if (mag >= den)
            cosv = 16384;
        else
        begin
            rem = mag;
            quo = 0;
            for (int i = 0; i < 14; i++)
            begin
                rem <<= 1;
                quo <<= 1;
                if (rem >= den)
                begin
                    rem -= den;
                    quo |= 1;
                end
            end
            cosv = quo;
        end
        if (num < 0)
            cosv = -cosv;
        quo = int_root(64'd268435456 - longint'(cosv * cosv));
        elbow = vector_angle(longint'(quo) <<< 30, cosv <<< 30);
        dir = vector_angle(dy <<< 20, dx <<< 20);
        return 1;
    endfunction

    function automatic logic signed [ANG_W-1:0] round_angle(longint v);
        longint r;
        r = (v + (64'sd1 <<< 17)) >>> 18;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[ANG_W-1:0];
    endfunction

    function automatic angles_t predict_angles(target_t t);
        angles_t a;
        longint ax;
        longint ay;
        longint a1;
        longint b1;
        longint a2;
        longint b2;
        ax = t.x;
        ay = t.y;
        a.left = 0;
        a.right = 0;
        a.stat = STAT_OK;
        if (ay >= 0)
            a.stat = STAT_Y_NONNEG;
        else if (!solve_side(ax + spacing_q8, ay, a1, b1))
            a.stat = STAT_LEFT_UNREACH;
        else if (!solve_side(ax - spacing_q8, ay, a2, b2))
            a.stat = STAT_RIGHT_UNREACH;
        else
        begin
            a.left = round_angle(a1 - b1);
            a.right = round_angle(a2 + b2);
        end
        return a;
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        if (errors < 40)
            $display("mismatch %s: got %0d want %0d", what, got, want);
    endtask

    // capture input transfers and predict
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            target_t t;
            t.x = target_x;
            t.y = target_y;
            expected_angles.push_back(predict_angles(t));
            items_taken++;
        end
    end

    // check output transfers against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            angles_t e;
            results_seen++;
            if (expected_angles.size() == 0)
                report("unexpected result", status, -1);
            else
            begin
                e = expected_angles.pop_front();
                if (status !== e.stat)
                    report("status", status, e.stat);
                if (left_angle !== e.left)
                    report("left_angle", left_angle, e.left);
                if (right_angle !== e.right)
                    report("right_angle", right_angle, e.right);
            end
        end
    end

    // sender: hold each item until its transfer, then idle a random gap
    int taken_done;
    int send_gap;
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || taken_done != items_taken))
        begin
            taken_done = items_taken;
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_targets.size() != 0)
            begin
                target_t t;
                t = pending_targets.pop_front();
                target_x <= t.x;
                target_y <= t.y;
                in_valid <= 1'b1;
                send_gap = gaps_on ? $urandom_range(0, 5) : 0;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver: random stall after each transfer, long hold on request
    int seen_done;
    int recv_gap;
    int hold_done;
    int hold_left;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_done != hold_orders)
            begin
                hold_done = hold_orders;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (seen_done != results_seen)
            begin
                seen_done = results_seen;
                recv_gap = gaps_on ? $urandom_range(0, 5) : 0;
                out_ready <= (recv_gap == 0);
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= (recv_gap == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic add_target(longint x, longint y);
        target_t t;
        t.x = x[POS_W-1:0];
        t.y = y[POS_W-1:0];
        pending_targets.push_back(t);
    endtask

    function automatic longint clip_pos(longint v);
        if (v > 8388607)
            return 8388607;
        if (v < -8388608)
            return -8388608;
        return v;
    endfunction

    // mostly targets in a box around a motor, sized by the arm lengths, some raw noise
    task automatic add_random(int n);
        longint span;
        longint cx;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                add_target($signed($urandom()), $signed($urandom()));
            else
            begin
                span = upper_q8 + lower_q8 + 2;
                if (span > 8388607)
                    span = 8388607;
                cx = $urandom_range(0, 1) ? spacing_q8 : -spacing_q8;
                add_target(clip_pos(cx + longint'($urandom_range(0, 2 * span)) - span),
                           clip_pos(-longint'($urandom_range(1, span))));
            end
        end
    endtask

    task automatic drain();
        while (pending_targets.size() != 0 || in_valid || expected_angles.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[LEN_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_HALF_SPACING)
            spacing_q8 = value;
        else if (idx == REG_UPPER_ARM)
            upper_q8 = value;
        else if (idx == REG_LOWER_ARM)
            lower_q8 = value;
    endtask

    task automatic set_leg(longint d, longint l1, longint l2);
        write_reg(REG_HALF_SPACING, d);
        write_reg(REG_UPPER_ARM, l1);
        write_reg(REG_LOWER_ARM, l2);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        target_x = '0;
        target_y = '0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        spacing_q8 = 0;
        upper_q8 = 256;
        lower_q8 = 512;
        gaps_on = 1'b1;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry: edges of reach, sign of y, field extremes
        add_target(0, -600);
        add_target(0, -768);
        add_target(0, -256);
        add_target(0, -255);
        add_target(0, -769);
        add_target(0, 0);
        add_target(100, 5);
        add_target(8388607, 8388607);
        add_target(-8388608, -8388608);
        add_target(-8388608, -1);
        add_target(8388607, -1);
        add_target(-1, -8388608);
        add_target(-600, -1);
        add_random(60);
        drain();

        // spaced motors: left and right reach cases
        set_leg(200, 256, 512);
        add_target(-200, -400);
        add_target(-400, -300);
        add_target(400, -300);
        add_target(0, -100);
        add_target(600, -100);
        add_random(30);
        // long output hold while the sender keeps offering
        hold_orders++;
        add_random(80);
        drain();

        // out-of-range index is ignored
        write_reg(2'd3, 12345);
        add_random(20);
        drain();

        // smallest arms
        set_leg(0, 1, 0);
        add_target(0, -1);
        add_target(1, -1);
        add_random(30);
        drain();

        // largest geometry
        set_leg(8388607, 8388607, 8388607);
        add_target(0, -8388608);
        add_target(8388607, -8388608);
        add_random(50);
        drain();

        set_leg(8388607, 8388607, 0);
        add_random(30);
        drain();

        // mid geometry, back to back then with gaps
        set_leg(1000, 3000, 5000);
        gaps_on = 1'b0;
        add_random(60);
        drain();
        gaps_on = 1'b1;
        add_random(60);
        drain();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ five_bar_leg_inverse_kinematics.f @@
+incdir+design
design/fbik_pkg.sv
design/fbik_cordic.sv
design/fbik_side.sv
design/five_bar_leg_inverse_kinematics.sv
design/fbik_checker.sv
tb/five_bar_leg_inverse_kinematics_test.sv
